>>> hdl/ccc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock counter package
// Field widths, calendar constants and request codes shared by the
// channel interfaces and the counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int unsigned MS_W    = 10;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DAYR_W  = 6;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned YOFS_W  = 8;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  localparam logic [MS_W-1:0]    MS_PER_SEC = MS_W'(1000);
  localparam logic [MS_W-1:0]    LOAD_MS    = MS_W'(500);
  localparam logic [YEAR_W-1:0]  BASE_YEAR  = YEAR_W'(2000);
  localparam logic [SEC_W-1:0]   SEC_PER_MIN  = SEC_W'(60);
  localparam logic [MIN_W-1:0]   MIN_PER_HOUR = MIN_W'(60);
  localparam logic [HOUR_W-1:0]  HOUR_PER_DAY = HOUR_W'(24);

  localparam logic [DAYR_W-1:0]  DAY_FIRST = DAYR_W'(1);
  localparam logic [DAYR_W-1:0]  DAY_29    = DAYR_W'(29);
  localparam logic [DAYR_W-1:0]  DAY_30    = DAYR_W'(30);
  localparam logic [DAYR_W-1:0]  DAY_31    = DAYR_W'(31);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

endpackage
`default_nettype wire

>>> hdl/ccc_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock command channel
// Valid/ready channel carrying one tick or load word.
// ----------------------------------------------------------------------------
interface ccc_cmd_if;
  logic                                valid;
  logic                                ready;
  ccc_pkg::req_t                       req_type;
  logic [ccc_pkg::MS_W-1:0]            ms_add;
  logic [ccc_pkg::YOFS_W-1:0]          load_year_offset;
  logic [ccc_pkg::MONTH_W-1:0]         load_month;
  logic [ccc_pkg::DAY_W-1:0]           load_date;
  logic [ccc_pkg::HOUR_W-1:0]          load_hour;
  logic [ccc_pkg::MIN_W-1:0]           load_minute;
  logic [ccc_pkg::SEC_W-1:0]           load_second;

  modport source (
    output valid, req_type, ms_add, load_year_offset, load_month, load_date,
           load_hour, load_minute, load_second,
    input  ready
  );
  modport sink (
    input  valid, req_type, ms_add, load_year_offset, load_month, load_date,
           load_hour, load_minute, load_second,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/ccc_time_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock time channel
// Valid/ready channel carrying one current-time word.
// ----------------------------------------------------------------------------
interface ccc_time_if;
  logic                          valid;
  logic                          ready;
  logic [ccc_pkg::MS_W-1:0]      cur_millisecond;
  logic [ccc_pkg::SEC_W-1:0]     cur_second;
  logic [ccc_pkg::MIN_W-1:0]     cur_minute;
  logic [ccc_pkg::HOUR_W-1:0]    cur_hour;
  logic [ccc_pkg::DAY_W-1:0]     cur_day;
  logic [ccc_pkg::MONTH_W-1:0]   cur_month;
  logic [ccc_pkg::YEAR_W-1:0]    cur_year;

  modport source (
    output valid, cur_millisecond, cur_second, cur_minute, cur_hour, cur_day,
           cur_month, cur_year,
    input  ready
  );
  modport sink (
    input  valid, cur_millisecond, cur_second, cur_minute, cur_hour, cur_day,
           cur_month, cur_year,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/calendar_clock_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock counter
// Millisecond-resolution date and time counter with tick and load words.
//
//   port   dir   word
//   cmd    sink  tick (ms_add) or load (date/time fields)
//   now    src   time after the word is applied, one per command word
//
// One command word per cycle; its time word is valid the next cycle.
// The time registers are the output register: a command is taken whenever
// the time word is empty or being taken in the same cycle.
// A stall on now holds the time and stalls cmd; no bubbles otherwise.
// Reset gives 00:00:00.000, January 1st, 2000, with no time word pending.
// ----------------------------------------------------------------------------
module calendar_clock_counter (
  input  wire logic  clk,
  input  wire logic  rst,
  ccc_cmd_if.sink    cmd,
  ccc_time_if.source now
);

  logic                             out_valid;
  logic [ccc_pkg::MS_W-1:0]         millis,       millis_next;
  logic [ccc_pkg::SEC_W-1:0]        seconds,      seconds_next;
  logic [ccc_pkg::MIN_W-1:0]        minutes,      minutes_next;
  logic [ccc_pkg::HOUR_W-1:0]       hours,        hours_next;
  logic [ccc_pkg::DAYR_W-1:0]       day_of_month, day_next;
  logic [ccc_pkg::MONTH_W-1:0]      month_number, month_next;
  logic [ccc_pkg::YEAR_W-1:0]       year_number,  year_next;

  logic                             accept;
  logic [ccc_pkg::MS_W:0]           ms_sum;
  logic [1:0]                       sec_carry;
  logic [ccc_pkg::SEC_W:0]          sec_sum;
  logic [ccc_pkg::MIN_W:0]          min_inc;
  logic [ccc_pkg::HOUR_W:0]         hour_inc;
  logic                             sec_wrap, min_wrap, hour_wrap;
  logic [ccc_pkg::DAYR_W-1:0]       day_inc;
  logic [ccc_pkg::MONTH_W-1:0]      month_inc;
  logic                             month_end, year_end;
  logic                             is_short;

  assign cmd.ready = !out_valid || now.ready;
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    ms_sum = (ccc_pkg::MS_W+1)'(millis) + (ccc_pkg::MS_W+1)'(cmd.ms_add);
    if (ms_sum >= (ccc_pkg::MS_W+1)'(2) * (ccc_pkg::MS_W+1)'(ccc_pkg::MS_PER_SEC)) begin
      sec_carry = 2'd2;
    end else if (ms_sum >= (ccc_pkg::MS_W+1)'(ccc_pkg::MS_PER_SEC)) begin
      sec_carry = 2'd1;
    end else begin
      sec_carry = 2'd0;
    end

    sec_sum   = (ccc_pkg::SEC_W+1)'(seconds) + (ccc_pkg::SEC_W+1)'(sec_carry);
    sec_wrap  = (sec_carry != 2'd0) &&
                (sec_sum >= (ccc_pkg::SEC_W+1)'(ccc_pkg::SEC_PER_MIN));
    min_inc   = (ccc_pkg::MIN_W+1)'(minutes) + (ccc_pkg::MIN_W+1)'(1);
    min_wrap  = sec_wrap && (min_inc >= (ccc_pkg::MIN_W+1)'(ccc_pkg::MIN_PER_HOUR));
    hour_inc  = (ccc_pkg::HOUR_W+1)'(hours) + (ccc_pkg::HOUR_W+1)'(1);
    hour_wrap = min_wrap && (hour_inc >= (ccc_pkg::HOUR_W+1)'(ccc_pkg::HOUR_PER_DAY));
    day_inc   = day_of_month + ccc_pkg::DAYR_W'(1);
    month_inc = month_number + ccc_pkg::MONTH_W'(1);

    is_short  = (month_number == ccc_pkg::MONTH_APR) || (month_number == ccc_pkg::MONTH_JUN) ||
                (month_number == ccc_pkg::MONTH_SEP) || (month_number == ccc_pkg::MONTH_NOV);
    month_end = 1'b0;
    year_end  = 1'b0;
    if (day_inc == ccc_pkg::DAY_29) begin
      month_end = (month_number == ccc_pkg::MONTH_FEB) && (year_number[1:0] != 2'b00);
    end else if (day_inc == ccc_pkg::DAY_30) begin
      month_end = (month_number == ccc_pkg::MONTH_FEB);
    end else if (day_inc == ccc_pkg::DAY_31) begin
      month_end = is_short;
    end else if (day_inc > ccc_pkg::DAY_31) begin
      month_end = 1'b1;
      year_end  = (month_number >= ccc_pkg::MONTH_DEC);
    end

    millis_next  = millis;
    seconds_next = seconds;
    minutes_next = minutes;
    hours_next   = hours;
    day_next     = day_of_month;
    month_next   = month_number;
    year_next    = year_number;

    if (cmd.req_type == ccc_pkg::REQ_LOAD) begin
      millis_next  = ccc_pkg::LOAD_MS;
      seconds_next = cmd.load_second;
      minutes_next = cmd.load_minute;
      hours_next   = cmd.load_hour;
      day_next     = ccc_pkg::DAYR_W'(cmd.load_date);
      month_next   = cmd.load_month;
      year_next    = ccc_pkg::BASE_YEAR + ccc_pkg::YEAR_W'(cmd.load_year_offset);
    end else begin
      case (sec_carry)
        2'd2:    millis_next = ccc_pkg::MS_W'(ms_sum - (ccc_pkg::MS_W+1)'(2000));
        2'd1:    millis_next = ccc_pkg::MS_W'(ms_sum - (ccc_pkg::MS_W+1)'(ccc_pkg::MS_PER_SEC));
        default: millis_next = ccc_pkg::MS_W'(ms_sum);
      endcase
      if (sec_wrap) begin
        seconds_next = ccc_pkg::SEC_W'(sec_sum - (ccc_pkg::SEC_W+1)'(ccc_pkg::SEC_PER_MIN));
        if (min_wrap) begin
          minutes_next = ccc_pkg::MIN_W'(min_inc - (ccc_pkg::MIN_W+1)'(ccc_pkg::MIN_PER_HOUR));
          if (hour_wrap) begin
            hours_next = ccc_pkg::HOUR_W'(hour_inc - (ccc_pkg::HOUR_W+1)'(ccc_pkg::HOUR_PER_DAY));
            if (month_end) begin
              day_next = ccc_pkg::DAY_FIRST;
              if (day_inc == ccc_pkg::DAY_29 || day_inc == ccc_pkg::DAY_30) begin
                month_next = ccc_pkg::MONTH_MAR;
              end else if (year_end) begin
                month_next = ccc_pkg::MONTH_JAN;
                year_next  = year_number + ccc_pkg::YEAR_W'(1);
              end else begin
                month_next = month_inc;
              end
            end else begin
              day_next = day_inc;
            end
          end else begin
            hours_next = ccc_pkg::HOUR_W'(hour_inc);
          end
        end else begin
          minutes_next = ccc_pkg::MIN_W'(min_inc);
        end
      end else if (sec_carry != 2'd0) begin
        seconds_next = ccc_pkg::SEC_W'(sec_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      millis       <= '0;
      seconds      <= '0;
      minutes      <= '0;
      hours        <= '0;
      day_of_month <= ccc_pkg::DAY_FIRST;
      month_number <= ccc_pkg::MONTH_JAN;
      year_number  <= ccc_pkg::BASE_YEAR;
    end else begin
      if (accept) begin
        out_valid    <= 1'b1;
        millis       <= millis_next;
        seconds      <= seconds_next;
        minutes      <= minutes_next;
        hours        <= hours_next;
        day_of_month <= day_next;
        month_number <= month_next;
        year_number  <= year_next;
      end else if (now.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign now.valid           = out_valid;
  assign now.cur_millisecond = millis;
  assign now.cur_second      = seconds;
  assign now.cur_minute      = minutes;
  assign now.cur_hour        = hours;
  assign now.cur_day         = day_of_month[ccc_pkg::DAY_W-1:0];
  assign now.cur_month       = month_number;
  assign now.cur_year        = year_number;

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar clock counter testbench
// Sends tick and load words to the counter and checks every returned time
// word against a local calendar model or a directed expected time.
// A directed table covers field extremes and month and year ends. Leap
// Februaries, out-of-range loads and months with no meaning are covered as
// well. Random words follow, most of them ticks, with loads near the end of a
// day and ticks large enough to carry. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_WORDS = 1000;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    ccc_pkg::req_t                kind;
    logic [ccc_pkg::MS_W-1:0]     ms_add;
    logic [ccc_pkg::YOFS_W-1:0]   year_ofs;
    logic [ccc_pkg::MONTH_W-1:0]  month;
    logic [ccc_pkg::DAY_W-1:0]    date;
    logic [ccc_pkg::HOUR_W-1:0]   hour;
    logic [ccc_pkg::MIN_W-1:0]    minute;
    logic [ccc_pkg::SEC_W-1:0]    second;
  } cmd_word_t;

  typedef struct packed {
    logic [ccc_pkg::MS_W-1:0]     millisecond;
    logic [ccc_pkg::SEC_W-1:0]    second;
    logic [ccc_pkg::MIN_W-1:0]    minute;
    logic [ccc_pkg::HOUR_W-1:0]   hour;
    logic [ccc_pkg::DAY_W-1:0]    day;
    logic [ccc_pkg::MONTH_W-1:0]  month;
    logic [ccc_pkg::YEAR_W-1:0]   year;
  } clock_time_t;

  typedef struct {
    cmd_word_t   word;
    bit          typed;
    clock_time_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   mismatches = 0;
  bit   calm_phase = 1'b0;

  logic [ccc_pkg::MS_W-1:0]    cal_ms;
  logic [ccc_pkg::SEC_W-1:0]   cal_sec;
  logic [ccc_pkg::MIN_W-1:0]   cal_min;
  logic [ccc_pkg::HOUR_W-1:0]  cal_hour;
  logic [ccc_pkg::DAYR_W-1:0]  cal_day;
  logic [ccc_pkg::MONTH_W-1:0] cal_month;
  logic [ccc_pkg::YEAR_W-1:0]  cal_year;

  clock_time_t expected_times[$];
  plan_row_t   plan[$];

  ccc_cmd_if  cmd_ch ();
  ccc_time_if now_ch ();

  calendar_clock_counter dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .now (now_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic cmd_word_t tick_w(int ms);
    cmd_word_t w;
    w = '0;
    w.kind = ccc_pkg::REQ_TICK;
    w.ms_add = ccc_pkg::MS_W'(ms);
    return w;
  endfunction

  function automatic cmd_word_t load_w(int yofs, int mo, int d, int h, int mi, int s);
    cmd_word_t w;
    w = '0;
    w.kind = ccc_pkg::REQ_LOAD;
    w.year_ofs = ccc_pkg::YOFS_W'(yofs);
    w.month = ccc_pkg::MONTH_W'(mo);
    w.date = ccc_pkg::DAY_W'(d);
    w.hour = ccc_pkg::HOUR_W'(h);
    w.minute = ccc_pkg::MIN_W'(mi);
    w.second = ccc_pkg::SEC_W'(s);
    return w;
  endfunction

  function automatic clock_time_t stamp(int ms, int s, int mi, int h, int d, int mo, int y);
    clock_time_t t;
    t.millisecond = ccc_pkg::MS_W'(ms);
    t.second = ccc_pkg::SEC_W'(s);
    t.minute = ccc_pkg::MIN_W'(mi);
    t.hour = ccc_pkg::HOUR_W'(h);
    t.day = ccc_pkg::DAY_W'(d);
    t.month = ccc_pkg::MONTH_W'(mo);
    t.year = ccc_pkg::YEAR_W'(y);
    return t;
  endfunction

  function automatic clock_time_t advance_clock(cmd_word_t w);
    int unsigned ms, s, mi, h;
    clock_time_t t;
    if (w.kind == ccc_pkg::REQ_LOAD) begin
      cal_year = ccc_pkg::BASE_YEAR + ccc_pkg::YEAR_W'(w.year_ofs);
      cal_month = w.month;
      cal_day = ccc_pkg::DAYR_W'(w.date);
      cal_hour = w.hour;
      cal_min = w.minute;
      cal_sec = w.second;
      cal_ms = ccc_pkg::LOAD_MS;
    end else begin
      ms = cal_ms + w.ms_add;
      if (ms < ccc_pkg::MS_PER_SEC) begin
        cal_ms = ccc_pkg::MS_W'(ms);
      end else begin
        s = cal_sec;
        while (ms >= ccc_pkg::MS_PER_SEC) begin
          ms -= ccc_pkg::MS_PER_SEC;
          s++;
        end
        cal_ms = ccc_pkg::MS_W'(ms);
        if (s < ccc_pkg::SEC_PER_MIN) begin
          cal_sec = ccc_pkg::SEC_W'(s);
        end else begin
          cal_sec = ccc_pkg::SEC_W'(s - ccc_pkg::SEC_PER_MIN);
          mi = cal_min + 1;
          if (mi < ccc_pkg::MIN_PER_HOUR) begin
            cal_min = ccc_pkg::MIN_W'(mi);
          end else begin
            cal_min = ccc_pkg::MIN_W'(mi - ccc_pkg::MIN_PER_HOUR);
            h = cal_hour + 1;
            if (h < ccc_pkg::HOUR_PER_DAY) begin
              cal_hour = ccc_pkg::HOUR_W'(h);
            end else begin
              cal_hour = ccc_pkg::HOUR_W'(h - ccc_pkg::HOUR_PER_DAY);
              cal_day = cal_day + 1'b1;
              // month end: leap rule is year mod 4 only
              if (cal_day == ccc_pkg::DAY_29) begin
                if (cal_month == ccc_pkg::MONTH_FEB && cal_year[1:0] != 2'b00) begin
                  cal_day = ccc_pkg::DAY_FIRST;
                  cal_month = ccc_pkg::MONTH_MAR;
                end
              end else if (cal_day == ccc_pkg::DAY_30) begin
                if (cal_month == ccc_pkg::MONTH_FEB) begin
                  cal_day = ccc_pkg::DAY_FIRST;
                  cal_month = ccc_pkg::MONTH_MAR;
                end
              end else if (cal_day == ccc_pkg::DAY_31) begin
                if (cal_month inside {ccc_pkg::MONTH_APR, ccc_pkg::MONTH_JUN,
                                      ccc_pkg::MONTH_SEP, ccc_pkg::MONTH_NOV}) begin
                  cal_day = ccc_pkg::DAY_FIRST;
                  cal_month = cal_month + 1'b1;
                end
              end else if (cal_day > ccc_pkg::DAY_31) begin
                cal_day = ccc_pkg::DAY_FIRST;
                if (cal_month >= ccc_pkg::MONTH_DEC) begin
                  cal_month = ccc_pkg::MONTH_JAN;
                  cal_year = cal_year + 1'b1;
                end else begin
                  cal_month = cal_month + 1'b1;
                end
              end
            end
          end
        end
      end
    end
    t.millisecond = cal_ms;
    t.second = cal_sec;
    t.minute = cal_min;
    t.hour = cal_hour;
    t.day = cal_day[ccc_pkg::DAY_W-1:0];
    t.month = cal_month;
    t.year = cal_year;
    return t;
  endfunction

  function automatic int idle_span();
    int r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_word(input cmd_word_t w, input bit typed, input clock_time_t want);
    int gap;
    clock_time_t model;
    gap = idle_span();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.req_type <= w.kind;
    cmd_ch.ms_add <= w.ms_add;
    cmd_ch.load_year_offset <= w.year_ofs;
    cmd_ch.load_month <= w.month;
    cmd_ch.load_date <= w.date;
    cmd_ch.load_hour <= w.hour;
    cmd_ch.load_minute <= w.minute;
    cmd_ch.load_second <= w.second;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    model = advance_clock(w);
    expected_times.push_back(typed ? want : model);
  endtask

  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_times.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int hold;
    now_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      now_ch.ready <= 1'b1;
      hold = $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
      hold = idle_span();
      if (hold > 0) begin
        now_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    clock_time_t want;
    if (!rst && now_ch.valid === 1'b1 && now_ch.ready === 1'b1) begin
      if (expected_times.size() == 0) begin
        $error("time word with no expectation pending");
        mismatches++;
      end else begin
        want = expected_times.pop_front();
        check_field("cur_millisecond", 32'(want.millisecond), 32'(now_ch.cur_millisecond));
        check_field("cur_second", 32'(want.second), 32'(now_ch.cur_second));
        check_field("cur_minute", 32'(want.minute), 32'(now_ch.cur_minute));
        check_field("cur_hour", 32'(want.hour), 32'(now_ch.cur_hour));
        check_field("cur_day", 32'(want.day), 32'(now_ch.cur_day));
        check_field("cur_month", 32'(want.month), 32'(now_ch.cur_month));
        check_field("cur_year", 32'(want.year), 32'(now_ch.cur_year));
      end
    end
  end

  initial begin
    cmd_word_t w;
    int pick;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.req_type <= ccc_pkg::REQ_TICK;
    cmd_ch.ms_add <= '0;
    cmd_ch.load_year_offset <= '0;
    cmd_ch.load_month <= '0;
    cmd_ch.load_date <= '0;
    cmd_ch.load_hour <= '0;
    cmd_ch.load_minute <= '0;
    cmd_ch.load_second <= '0;
    cal_ms = '0;
    cal_sec = '0;
    cal_min = '0;
    cal_hour = '0;
    cal_day = ccc_pkg::DAY_FIRST;
    cal_month = ccc_pkg::MONTH_JAN;
    cal_year = ccc_pkg::BASE_YEAR;

    plan = '{
      '{tick_w(0),                       1'b1, stamp(0, 0, 0, 0, 1, 1, 2000)},
      '{tick_w(999),                     1'b1, stamp(999, 0, 0, 0, 1, 1, 2000)},
      '{tick_w(1),                       1'b0, '0},
      '{tick_w(1023),                    1'b0, '0},
      '{tick_w(1000),                    1'b0, '0},
      '{load_w(255, 12, 31, 23, 59, 59), 1'b1, stamp(500, 59, 59, 23, 31, 12, 2255)},
      '{tick_w(500),                     1'b0, '0},
      '{load_w(1, 2, 28, 23, 59, 59),    1'b1, stamp(500, 59, 59, 23, 28, 2, 2001)},
      '{tick_w(500),                     1'b0, '0},
      '{load_w(4, 2, 28, 23, 59, 59),    1'b1, stamp(500, 59, 59, 23, 28, 2, 2004)},
      '{tick_w(500),                     1'b0, '0},
      '{load_w(4, 2, 29, 23, 59, 59),    1'b1, stamp(500, 59, 59, 23, 29, 2, 2004)},
      '{tick_w(500),                     1'b0, '0},
      '{load_w(0, 4, 30, 23, 59, 59),    1'b1, stamp(500, 59, 59, 23, 30, 4, 2000)},
      '{tick_w(500),                     1'b0, '0},
      '{load_w(0, 1, 31, 23, 59, 59),    1'b1, stamp(500, 59, 59, 23, 31, 1, 2000)},
      '{tick_w(500),                     1'b0, '0},
      '{load_w(0, 0, 31, 31, 63, 63),    1'b1, stamp(500, 63, 63, 31, 31, 0, 2000)},
      '{tick_w(1023),                    1'b0, '0},
      '{load_w(17, 15, 31, 23, 59, 59),  1'b1, stamp(500, 59, 59, 23, 31, 15, 2017)},
      '{tick_w(500),                     1'b0, '0},
      '{load_w(2, 13, 30, 23, 59, 59),   1'b1, stamp(500, 59, 59, 23, 30, 13, 2002)},
      '{tick_w(500),                     1'b0, '0},
      '{load_w(0, 0, 0, 0, 0, 0),        1'b1, stamp(500, 0, 0, 0, 0, 0, 2000)}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);
    wait_for_drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) calm_phase = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_WORDS / 2) wait_for_drain();
      w.kind = ($urandom_range(0, 3) == 0) ? ccc_pkg::REQ_LOAD : ccc_pkg::REQ_TICK;
      pick = $urandom_range(0, 9);
      if (pick < 5) w.ms_add = ccc_pkg::MS_W'($urandom_range(0, 1000));
      else if (pick < 8) w.ms_add = ccc_pkg::MS_W'($urandom_range(900, 1023));
      else w.ms_add = ccc_pkg::MS_W'($urandom);
      w.year_ofs = ccc_pkg::YOFS_W'($urandom);
      w.month = ($urandom_range(0, 9) == 0) ? ccc_pkg::MONTH_W'($urandom)
                                             : ccc_pkg::MONTH_W'($urandom_range(1, 12));
      w.date = ($urandom_range(0, 9) < 7) ? ccc_pkg::DAY_W'($urandom_range(27, 31))
                                          : ccc_pkg::DAY_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        w.hour = ccc_pkg::HOUR_W'(23);
        w.minute = ccc_pkg::MIN_W'(59);
        w.second = ccc_pkg::SEC_W'($urandom_range(55, 59));
      end else if (pick < 9) begin
        w.hour = ccc_pkg::HOUR_W'($urandom_range(0, 23));
        w.minute = ccc_pkg::MIN_W'($urandom_range(0, 59));
        w.second = ccc_pkg::SEC_W'($urandom_range(0, 59));
      end else begin
        w.hour = ccc_pkg::HOUR_W'($urandom);
        w.minute = ccc_pkg::MIN_W'($urandom);
        w.second = ccc_pkg::SEC_W'($urandom);
      end
      send_word(w, 1'b0, '0);
    end

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
